@@ design/mmq_pkg.sv @@
// ----------------------------------------------------------------------------
// mmq_pkg
// Shared constants for the masked share multiplier: share and pair counts,
// lane layout, pipeline stage map and the modulus register.
// ----------------------------------------------------------------------------
`default_nettype none

package mmq_pkg;

  localparam int unsigned SHARE_BITS_DEF = 15;
  localparam int unsigned SHARE_COUNT    = 3;
  localparam int unsigned PAIR_COUNT     = (SHARE_COUNT * (SHARE_COUNT - 1)) / 2;

  // reduction lanes: a shares, b shares, masks / diagonal and cross products
  localparam int unsigned IN_LANES   = 2 * SHARE_COUNT + PAIR_COUNT;
  localparam int unsigned PROD_LANES = SHARE_COUNT + 2 * PAIR_COUNT;

  // terms summed per output share: diagonal, one mask per partner,
  // two cross products per lower partner
  localparam int unsigned TERM_MAX   = 3 * (SHARE_COUNT - 1) + 1;
  localparam int unsigned TREE_LVLS  = $clog2(TERM_MAX);
  localparam int unsigned TERM_SLOTS = 1 << TREE_LVLS;
  localparam int unsigned HALF_SLOTS = TERM_SLOTS / 2;

  // pipeline stage map
  localparam int unsigned RED_STAGES = 3;
  localparam int unsigned ST_PROD    = RED_STAGES;
  localparam int unsigned ST_RED2    = RED_STAGES + 1;
  localparam int unsigned ST_TREE    = 2 * RED_STAGES + 1;
  localparam int unsigned NUM_STAGES = ST_TREE + TREE_LVLS;

  // modulus register
  localparam int unsigned MOD_W     = 16;
  localparam int unsigned MOD_RESET = 3329;

endpackage

`default_nettype wire

@@ design/mmq_in_if.sv @@
// ----------------------------------------------------------------------------
// mmq_in_if
// Operand channel: three shares of each operand and one mask per share pair.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmq_in_if import mmq_pkg::*; #(
  parameter int unsigned SHARE_BITS = SHARE_BITS_DEF
);

  logic                  valid;
  logic                  ready;
  logic [SHARE_BITS-1:0] a_share0;
  logic [SHARE_BITS-1:0] a_share1;
  logic [SHARE_BITS-1:0] a_share2;
  logic [SHARE_BITS-1:0] b_share0;
  logic [SHARE_BITS-1:0] b_share1;
  logic [SHARE_BITS-1:0] b_share2;
  logic [SHARE_BITS-1:0] mask_01;
  logic [SHARE_BITS-1:0] mask_02;
  logic [SHARE_BITS-1:0] mask_12;

  modport source (
    output valid, a_share0, a_share1, a_share2, b_share0, b_share1, b_share2,
           mask_01, mask_02, mask_12,
    input  ready
  );

  modport sink (
    input  valid, a_share0, a_share1, a_share2, b_share0, b_share1, b_share2,
           mask_01, mask_02, mask_12,
    output ready
  );

endinterface

`default_nettype wire

@@ design/mmq_out_if.sv @@
// ----------------------------------------------------------------------------
// mmq_out_if
// Result channel: three shares of the product modulo q.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmq_out_if import mmq_pkg::*; #(
  parameter int unsigned SHARE_BITS = SHARE_BITS_DEF
);

  logic                  valid;
  logic                  ready;
  logic [SHARE_BITS-1:0] c_share0;
  logic [SHARE_BITS-1:0] c_share1;
  logic [SHARE_BITS-1:0] c_share2;

  modport source (
    output valid, c_share0, c_share1, c_share2,
    input  ready
  );

  modport sink (
    input  valid, c_share0, c_share1, c_share2,
    output ready
  );

endinterface

`default_nettype wire

@@ design/mmq_modcfg.sv @@
// ----------------------------------------------------------------------------
// mmq_modcfg
// Modulus register with clamping, plus a bit-serial divider that derives the
// reduction constant mu = floor(2^(2*SHARE_BITS) / q) after every write.
// ----------------------------------------------------------------------------
`default_nettype none

module mmq_modcfg import mmq_pkg::*; #(
  parameter int unsigned SHARE_BITS = SHARE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [MOD_W-1:0]        cfg_wdata,
  output logic [SHARE_BITS:0]     q,
  output logic [2*SHARE_BITS:0]   mu,
  output logic                    busy
);

  localparam int unsigned QW    = SHARE_BITS + 1;
  localparam int unsigned MUW   = 2 * SHARE_BITS + 1;
  localparam int unsigned STW   = $clog2(MUW);
  localparam int unsigned CW    = MUW + QW;
  localparam int unsigned CAP_I = 1 << SHARE_BITS;
  localparam int unsigned Q_RST = (MOD_RESET > CAP_I) ? CAP_I : MOD_RESET;
  localparam int unsigned MU_RST = (1 << (2 * SHARE_BITS)) / Q_RST;
  localparam logic [MOD_W-1:0] CAP      = MOD_W'(CAP_I);
  localparam logic [STW-1:0]   LAST_STEP = STW'(MUW - 1);

  logic [QW-1:0]  q_r, q_nxt;
  logic [MUW-1:0] mu_r, mu_nxt;
  logic [QW-1:0]  rem_r, rem_nxt;
  logic [STW-1:0] step_r, step_nxt;
  logic           busy_r;
  logic [QW:0]    sh;
  logic [QW:0]    sh_sub;
  logic           ge;

  // clamp the written modulus into 1 .. 2^SHARE_BITS
  always_comb begin
    priority if (cfg_wdata < MOD_W'(2)) begin
      q_nxt = QW'(1);
    end else if (cfg_wdata > CAP) begin
      q_nxt = QW'(CAP);
    end else begin
      q_nxt = cfg_wdata[QW-1:0];
    end
  end

  // restoring division of 2^(2*SHARE_BITS) by q, msb first
  always_comb begin
    sh       = {rem_r, (step_r == '0)};
    sh_sub   = sh - {1'b0, q_r};
    ge       = (sh >= {1'b0, q_r});
    rem_nxt  = ge ? sh_sub[QW-1:0] : sh[QW-1:0];
    mu_nxt   = {mu_r[MUW-2:0], ge};
    step_nxt = step_r + STW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r    <= QW'(Q_RST);
      mu_r   <= MUW'(MU_RST);
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (cfg_we) begin
      q_r    <= q_nxt;
      busy_r <= 1'b1;
      step_r <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      mu_r   <= mu_nxt;
      step_r <= step_nxt;
      if (step_r == LAST_STEP) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign q    = q_r;
  assign mu   = mu_r;
  assign busy = busy_r;

  logic [CW-1:0] chk_prod;
  assign chk_prod = CW'(mu_r) * CW'(q_r);

  // mu must be the exact floor quotient whenever the datapath may use it
  a_mu_exact: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (chk_prod <= (CW'(1) << (2 * SHARE_BITS))) &&
                ((CW'(1) << (2 * SHARE_BITS)) - chk_prod < CW'(q_r)))
    else $error("reduction constant does not match modulus");

  a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
    (q_r != '0) && (q_r <= QW'(CAP)))
    else $error("effective modulus out of range");

endmodule

`default_nettype wire

@@ design/mmq_reduce.sv @@
// ----------------------------------------------------------------------------
// mmq_reduce
// Three-stage Barrett reduction of several lanes by the configured modulus:
// quotient estimate, remainder, final correction.
// ----------------------------------------------------------------------------
`default_nettype none

module mmq_reduce import mmq_pkg::*; #(
  parameter int unsigned SHARE_BITS = SHARE_BITS_DEF,
  parameter int unsigned XW         = 2 * SHARE_BITS_DEF,
  parameter int unsigned LANES      = PROD_LANES
) (
  input  logic                  clk,
  input  logic [RED_STAGES-1:0] en,
  input  logic [SHARE_BITS:0]   q,
  input  logic [XW:0]           mu,
  input  logic [XW-1:0]         x   [LANES],
  output logic [SHARE_BITS-1:0] res [LANES]
);

  localparam int unsigned QW = SHARE_BITS + 1;

  logic [2*XW:0]         prod1   [LANES];
  logic [XW+QW-1:0]      prod2   [LANES];
  logic [QW-1:0]         rem_sub [LANES];
  logic [XW-1:0]         x_r     [LANES];
  logic [XW-1:0]         qh_r    [LANES];
  logic [XW-1:0]         qh_nxt  [LANES];
  logic [QW-1:0]         rem_r   [LANES];
  logic [QW-1:0]         rem_nxt [LANES];
  logic [SHARE_BITS-1:0] res_r   [LANES];
  logic [SHARE_BITS-1:0] res_nxt [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      // quotient estimate is low by at most one
      prod1[l]   = x[l] * mu;
      qh_nxt[l]  = prod1[l][2*XW-1:XW];
      prod2[l]   = qh_r[l] * q;
      rem_nxt[l] = QW'(x_r[l]) - prod2[l][QW-1:0];
      rem_sub[l] = rem_r[l] - q;
      res_nxt[l] = (rem_r[l] >= q) ? rem_sub[l][SHARE_BITS-1:0]
                                   : rem_r[l][SHARE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r  <= x;
      qh_r <= qh_nxt;
    end
    if (en[1]) begin
      rem_r <= rem_nxt;
    end
    if (en[2]) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

@@ design/masked_mult_mod_q.sv @@
// ----------------------------------------------------------------------------
// masked_mult_mod_q
// Three-share masked multiplication modulo q (ISW gadget).
//
// in_ch carries the shares a0..a2, b0..b2 and the pair masks m01, m02, m12;
// out_ch carries the product shares c0..c2, all modulo the configured q.
// cfg_we / cfg_wdata write the modulus; values below two act as one, values
// above 2^SHARE_BITS are clamped to 2^SHARE_BITS.
// Ten register stages: Barrett reduction of the inputs (3), share products
// (1), Barrett reduction of the products (3), a modular adder tree (3).
// Throughput is one beat per cycle while out_ch.ready is high and no
// modulus write is in progress. Every stage has its own valid bit and
// advances when the stage after it is empty or moving, so a stalled output
// only holds the beats stacked behind it and bubbles are squeezed out.
// After reset q is 3329 and the block is ready at once. A modulus write holds
// in_ch.ready low while the bit-serial divider in mmq_modcfg derives the
// reduction constant.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_mult_mod_q import mmq_pkg::*; #(
  parameter int unsigned SHARE_BITS = SHARE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  mmq_in_if.sink           in_ch,
  mmq_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [MOD_W-1:0] cfg_wdata
);

  localparam int unsigned W   = SHARE_BITS;
  localparam int unsigned QW  = SHARE_BITS + 1;
  localparam int unsigned PW  = 2 * SHARE_BITS;
  localparam int unsigned MUW = 2 * SHARE_BITS + 1;

  logic [QW-1:0]  q;
  logic [MUW-1:0] mu;
  logic           busy;

  logic [NUM_STAGES:0]   en;
  logic [NUM_STAGES-1:0] v_r, v_nxt;

  logic [W-1:0]  x1       [IN_LANES];
  logic [W-1:0]  res1     [IN_LANES];
  logic [PW-1:0] prod_nxt [PROD_LANES];
  logic [PW-1:0] prod_r   [PROD_LANES];
  logic [W-1:0]  res2     [PROD_LANES];
  logic [W-1:0]  rpos_nxt [PAIR_COUNT];
  logic [W-1:0]  rneg_nxt [PAIR_COUNT];
  logic [W-1:0]  rpos_r   [RED_STAGES+1][PAIR_COUNT];
  logic [W-1:0]  rneg_r   [RED_STAGES+1][PAIR_COUNT];
  logic [W-1:0]  term     [SHARE_COUNT][TERM_SLOTS];
  logic [W-1:0]  tree_nxt [TREE_LVLS][SHARE_COUNT][HALF_SLOTS];
  logic [W-1:0]  tree_r   [TREE_LVLS][SHARE_COUNT][HALF_SLOTS];

  function automatic logic [W-1:0] mod_add(input logic [W-1:0]  x,
                                           input logic [W-1:0]  y,
                                           input logic [QW-1:0] m);
    logic [QW-1:0] s;
    logic [QW-1:0] d;
    s = QW'(x) + QW'(y);
    d = s - m;
    return (s >= m) ? d[W-1:0] : s[W-1:0];
  endfunction

  mmq_modcfg #(
    .SHARE_BITS (SHARE_BITS)
  ) u_modcfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q         (q),
    .mu        (mu),
    .busy      (busy)
  );

  // stage handshake: a stage moves when it is empty or its successor moves
  assign en[NUM_STAGES] = out_ch.ready;
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_en
    assign en[k] = ~v_r[k] | en[k+1];
  end

  assign in_ch.ready = en[0] & ~busy;
  assign v_nxt       = {v_r[NUM_STAGES-2:0], in_ch.valid & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_nxt[k];
        end
      end
    end
  end

  // lane order follows the beat: a shares, b shares, masks
  assign x1[0] = in_ch.a_share0;
  assign x1[1] = in_ch.a_share1;
  assign x1[2] = in_ch.a_share2;
  assign x1[3] = in_ch.b_share0;
  assign x1[4] = in_ch.b_share1;
  assign x1[5] = in_ch.b_share2;
  assign x1[6] = in_ch.mask_01;
  assign x1[7] = in_ch.mask_02;
  assign x1[8] = in_ch.mask_12;

  mmq_reduce #(
    .SHARE_BITS (SHARE_BITS),
    .XW         (W),
    .LANES      (IN_LANES)
  ) u_red_in (
    .clk (clk),
    .en  (en[RED_STAGES-1:0]),
    .q   (q),
    .mu  (mu[MUW-1:W]),
    .x   (x1),
    .res (res1)
  );

  // share products and signed mask terms
  always_comb begin
    int k;
    k = 0;
    for (int i = 0; i < SHARE_COUNT; i++) begin
      prod_nxt[i] = res1[i] * res1[SHARE_COUNT+i];
    end
    for (int i = 0; i < SHARE_COUNT; i++) begin
      for (int j = i + 1; j < SHARE_COUNT; j++) begin
        prod_nxt[SHARE_COUNT+2*k]   = res1[i] * res1[SHARE_COUNT+j];
        prod_nxt[SHARE_COUNT+2*k+1] = res1[j] * res1[SHARE_COUNT+i];
        rpos_nxt[k] = res1[2*SHARE_COUNT+k];
        rneg_nxt[k] = (res1[2*SHARE_COUNT+k] == '0) ? '0
                      : W'(q - QW'(res1[2*SHARE_COUNT+k]));
        k = k + 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_PROD]) begin
      prod_r    <= prod_nxt;
      rpos_r[0] <= rpos_nxt;
      rneg_r[0] <= rneg_nxt;
    end
    for (int d = 1; d <= RED_STAGES; d++) begin
      if (en[ST_PROD+d]) begin
        rpos_r[d] <= rpos_r[d-1];
        rneg_r[d] <= rneg_r[d-1];
      end
    end
  end

  mmq_reduce #(
    .SHARE_BITS (SHARE_BITS),
    .XW         (PW),
    .LANES      (PROD_LANES)
  ) u_red_prod (
    .clk (clk),
    .en  (en[ST_RED2 +: RED_STAGES]),
    .q   (q),
    .mu  (mu),
    .x   (prod_r),
    .res (res2)
  );

  // share i: diagonal, minus masks of higher partners, plus mask and
  // both cross terms of lower partners
  always_comb begin
    int cnt [SHARE_COUNT];
    int k;
    k = 0;
    for (int s = 0; s < SHARE_COUNT; s++) begin
      for (int t = 0; t < TERM_SLOTS; t++) begin
        term[s][t] = '0;
      end
      term[s][0] = res2[s];
      cnt[s]     = 1;
    end
    for (int i = 0; i < SHARE_COUNT; i++) begin
      for (int j = i + 1; j < SHARE_COUNT; j++) begin
        term[i][cnt[i]] = rneg_r[RED_STAGES][k];
        cnt[i]          = cnt[i] + 1;
        term[j][cnt[j]] = rpos_r[RED_STAGES][k];
        cnt[j]          = cnt[j] + 1;
        term[j][cnt[j]] = res2[SHARE_COUNT+2*k];
        cnt[j]          = cnt[j] + 1;
        term[j][cnt[j]] = res2[SHARE_COUNT+2*k+1];
        cnt[j]          = cnt[j] + 1;
        k = k + 1;
      end
    end
  end

  // modular adder tree, one level per stage
  always_comb begin
    for (int l = 0; l < TREE_LVLS; l++) begin
      for (int s = 0; s < SHARE_COUNT; s++) begin
        for (int e = 0; e < HALF_SLOTS; e++) begin
          tree_nxt[l][s][e] = '0;
        end
      end
    end
    for (int s = 0; s < SHARE_COUNT; s++) begin
      for (int e = 0; e < HALF_SLOTS; e++) begin
        tree_nxt[0][s][e] = mod_add(term[s][2*e], term[s][2*e+1], q);
      end
    end
    for (int l = 1; l < TREE_LVLS; l++) begin
      for (int s = 0; s < SHARE_COUNT; s++) begin
        for (int e = 0; e < (TERM_SLOTS >> (l + 1)); e++) begin
          tree_nxt[l][s][e] = mod_add(tree_r[l-1][s][2*e], tree_r[l-1][s][2*e+1], q);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < TREE_LVLS; l++) begin
      if (en[ST_TREE+l]) begin
        tree_r[l] <= tree_nxt[l];
      end
    end
  end

  assign out_ch.valid    = v_r[NUM_STAGES-1];
  assign out_ch.c_share0 = tree_r[TREE_LVLS-1][0][0];
  assign out_ch.c_share1 = tree_r[TREE_LVLS-1][1][0];
  assign out_ch.c_share2 = tree_r[TREE_LVLS-1][2][0];

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ch.ready)
    else $error("input taken while reduction constant is being derived");

  a_out_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (QW'(out_ch.c_share0) < q) && (QW'(out_ch.c_share1) < q) &&
                     (QW'(out_ch.c_share2) < q))
    else $error("result share not reduced below modulus");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v_r[0])
    else $error("accepted beat did not enter the first stage");

endmodule

`default_nettype wire
